// ===== rtl/dcn_pkg.sv =====
// Shared types, constants and the group reading function for the Chinese numeral unit.
// No dependencies; every other file in this folder imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dcn_pkg;

   localparam int MAX_DIGITS   = 8;
   localparam int DIGIT_W      = 4;
   localparam int COUNT_W      = 4;
   localparam int BCD_W        = 32;
   localparam int GROUP_DIGITS = 4;
   localparam int GROUP_W      = GROUP_DIGITS * DIGIT_W;
   localparam int GROUP_SLOTS  = 7;
   localparam int ENTRY_SLOTS  = 2 * GROUP_SLOTS + 1;
   localparam int SIZE_W       = 3;

   typedef logic [DIGIT_W-1:0] token_type;

   localparam token_type TOK_ZERO     = 4'd0;
   localparam token_type TOK_NINE     = 4'd9;
   localparam token_type TOK_ONE      = 4'd1;
   localparam token_type TOK_TEN      = 4'd10;
   localparam token_type TOK_HUNDRED  = 4'd11;
   localparam token_type TOK_THOUSAND = 4'd12;
   localparam token_type TOK_WAN      = 4'd13;

   typedef struct packed {
      logic [BCD_W-1:0]   bcd_digits;
      logic [COUNT_W-1:0] digit_count;
   } req_type;

   typedef struct packed {
      token_type token;
      logic      last;
   } rsp_type;

   // Slots of one group: even slots hold digit words, odd slots the unit after them.
   typedef struct packed {
      token_type [GROUP_SLOTS-1:0] tok;
      logic [GROUP_SLOTS-1:0]      keep;
   } group_type;

   // Upper group, then wan, then lower group; slot 0 is spoken first.
   typedef struct packed {
      token_type [ENTRY_SLOTS-1:0] tok;
      logic [ENTRY_SLOTS-1:0]      keep;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic token_type sat_digit(input logic [DIGIT_W-1:0] nib);
      sat_digit = (nib > TOK_NINE) ? TOK_NINE : nib;
   endfunction

   // Reads the lowest size digits of nib as a group, right aligned in the slots.
   function automatic group_type read_group(input logic [GROUP_W-1:0] nib,
                                            input logic [SIZE_W-1:0]  size);
      group_type                    g;
      token_type [GROUP_DIGITS-1:0] d;
      logic                         zp;
      logic [1:0]                   lastz;
      for (int p = 0; p < GROUP_DIGITS; p++) begin
         d[p] = sat_digit(nib[(GROUP_DIGITS-1-p)*DIGIT_W +: DIGIT_W]);
      end
      g.tok[0] = d[0];
      g.tok[1] = TOK_THOUSAND;
      g.tok[2] = d[1];
      g.tok[3] = TOK_HUNDRED;
      g.tok[4] = d[2];
      g.tok[5] = TOK_TEN;
      g.tok[6] = d[3];
      g.keep   = '0;
      zp       = 1'b0;
      lastz    = 2'd0;
      case (size)
         3'd1: begin
            g.keep[6] = 1'b1;
         end
         3'd2: begin
            // A leading one before ten is not spoken.
            g.keep[4] = (d[2] != TOK_ZERO) && (d[2] != TOK_ONE);
            g.keep[5] = (d[2] != TOK_ZERO);
            g.keep[6] = (d[3] != TOK_ZERO);
         end
         3'd3: begin
            g.keep[2] = 1'b1;
            g.keep[3] = 1'b1;
            g.keep[4] = (d[2] != TOK_ZERO) || (d[3] != TOK_ZERO);
            g.keep[5] = (d[2] != TOK_ZERO);
            g.keep[6] = (d[3] != TOK_ZERO);
         end
         default: begin
            for (int p = 0; p < GROUP_DIGITS - 1; p++) begin
               if (d[p] != TOK_ZERO) begin
                  g.keep[2*p]   = 1'b1;
                  g.keep[2*p+1] = 1'b1;
                  zp            = 1'b0;
               end else if (!zp) begin
                  g.keep[2*p] = 1'b1;
                  zp          = 1'b1;
                  lastz       = 2'(p);
               end
            end
            if (d[3] != TOK_ZERO) begin
               g.keep[6] = 1'b1;
            end else if (zp) begin
               // A zero word that would end the group is removed.
               g.keep[{lastz, 1'b0}] = 1'b0;
            end
         end
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dcn_front.sv =====
// Front end: takes a request, splits it into digit groups and builds the slot mask.
// Depends on dcn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcn_front (
   input  wire                        req_valid,
   output logic                       req_stall,
   input  dcn_pkg::req_type           req_payload,
   input  dcn_pkg::queue_status_type  q_status,
   output logic                       push,
   output dcn_pkg::entry_type         push_entry
);
   import dcn_pkg::*;

   logic [COUNT_W-1:0] cnt;
   logic               split;
   logic [GROUP_W-1:0] head_nib;
   logic [SIZE_W-1:0]  head_size;
   group_type          upper;
   group_type          lower;

   always_comb begin
      cnt = req_payload.digit_count;
      if (cnt == '0) begin
         cnt = COUNT_W'(1);
      end else if (cnt > COUNT_W'(MAX_DIGITS)) begin
         cnt = COUNT_W'(MAX_DIGITS);
      end
   end

   assign split     = (cnt > COUNT_W'(GROUP_DIGITS));
   assign head_nib  = split ? req_payload.bcd_digits[BCD_W-1:GROUP_W]
                            : req_payload.bcd_digits[GROUP_W-1:0];
   assign head_size = split ? SIZE_W'(cnt - COUNT_W'(GROUP_DIGITS)) : SIZE_W'(cnt);

   assign upper = read_group(head_nib, head_size);
   assign lower = read_group(req_payload.bcd_digits[GROUP_W-1:0], SIZE_W'(GROUP_DIGITS));

   always_comb begin
      push_entry.tok  = {lower.tok, TOK_WAN, upper.tok};
      push_entry.keep = {(split ? lower.keep : {GROUP_SLOTS{1'b0}}), split, upper.keep};
   end

   // A request that reads as nothing is taken but never queued.
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full && (push_entry.keep != '0);

endmodule

`default_nettype wire

// ===== rtl/dcn_queue.sv =====
// Two-entry queue of decoded readings between the front end and the token sequencer.
// Depends on dcn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcn_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  dcn_pkg::entry_type         push_entry,
   input  wire                        pop,
   output dcn_pkg::entry_type         head_entry,
   output dcn_pkg::queue_status_type  q_status
);
   import dcn_pkg::*;

   entry_type  mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_entry     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dcn_back.sv =====
// Back end: walks the slot mask of the queued reading and sends one token a cycle while rsp_stall is low.
// Depends on dcn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcn_back (
   input  wire                        clock,
   input  wire                        reset,
   input  dcn_pkg::queue_status_type  q_status,
   input  dcn_pkg::entry_type         head_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output dcn_pkg::rsp_type           rsp_payload
);
   import dcn_pkg::*;

   logic [ENTRY_SLOTS-1:0]      mask_ff;
   logic [ENTRY_SLOTS-1:0]      mask_in;
   token_type [ENTRY_SLOTS-1:0] tok_ff;
   token_type [ENTRY_SLOTS-1:0] tok_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   rsp_type                     rsp_ff;
   rsp_type                     rsp_in;
   logic [ENTRY_SLOTS-1:0]      first_hot;
   logic [ENTRY_SLOTS-1:0]      rest;
   token_type                   sel_tok;
   logic                        can_emit;
   logic                        emit;

   assign first_hot = mask_ff & (~mask_ff + ENTRY_SLOTS'(1));
   assign rest      = mask_ff & ~first_hot;

   always_comb begin
      sel_tok = TOK_ZERO;
      for (int i = 0; i < ENTRY_SLOTS; i++) begin
         sel_tok = sel_tok | (tok_ff[i] & {DIGIT_W{first_hot[i]}});
      end
   end

   assign can_emit = !rsp_valid_ff || !rsp_stall;
   assign emit     = can_emit && (mask_ff != '0);
   // The next reading loads as soon as the current one sends its final token.
   assign pop      = !q_status.empty && ((mask_ff == '0) || (emit && (rest == '0)));

   always_comb begin
      mask_in      = mask_ff;
      tok_in       = tok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (pop) begin
         mask_in = head_entry.keep;
         tok_in  = head_entry.tok;
      end else if (emit) begin
         mask_in = rest;
      end
      if (can_emit) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_in.token = sel_tok;
         rsp_in.last  = (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/decimal_to_chinese_numeral_unit.sv =====
// Chinese numeral reading unit: one request of up to eight BCD digits in, its tokens out.
// Path: an accepted request passes the queue, the sequencer mask and the output register before rsp_valid.
// Throughput: one token per cycle while rsp_stall is low; the token sequencer loads the next request as
// the last token is sent, and a new request is accepted every cycle while the two-entry queue has room.
// Reset: synchronous, active high; clears the queue, the sequencer mask and the output valid flag.
// Depends on dcn_pkg, dcn_front, dcn_queue and dcn_back.
`timescale 1ns / 1ps
`default_nettype none

module decimal_to_chinese_numeral_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  dcn_pkg::req_type   req_payload,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output dcn_pkg::rsp_type   rsp_payload
);
   import dcn_pkg::*;

   queue_status_type q_status;
   entry_type        push_entry;
   entry_type        head_entry;
   logic             push;
   logic             pop;

   dcn_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   dcn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   dcn_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== tb/sv/dcn_reading_checker.sv =====
// Checker for the Chinese numeral unit: predicts the token run of every accepted request
// and compares each accepted token with the oldest prediction. Depends on dcn_pkg.
`timescale 1ns / 1ps

module dcn_reading_checker
   import dcn_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   input  wire     req_stall,
   input  req_type req_payload,
   input  wire     rsp_valid,
   input  wire     rsp_stall,
   input  rsp_type rsp_payload,
   output int      pending_tokens,
   output int      error_count
);

   localparam int REPORT_LIMIT = 10;

   token_type spoken[$];
   rsp_type   expected_tokens[$];
   int        mismatches = 0;

   function automatic void add_word(input token_type w);
      spoken = {spoken, w};
   endfunction

   function automatic void drop_word();
      if (spoken.size() > 0) begin
         spoken.delete(spoken.size() - 1);
      end
   endfunction

   function automatic token_type nibble_digit(input logic [BCD_W-1:0] bcd, input int pos);
      token_type v;
      v = token_type'(bcd >> (DIGIT_W * pos));
      return (v > TOK_NINE) ? TOK_NINE : v;
   endfunction

   // Full four-digit group; d[0] is the thousands digit.
   function automatic void read_four(input token_type [0:3] d);
      logic zpend;
      zpend = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (d[i] != TOK_ZERO) begin
            add_word(d[i]);
            add_word((i == 0) ? TOK_THOUSAND : (i == 1) ? TOK_HUNDRED : TOK_TEN);
            zpend = 1'b0;
         end else if (!zpend) begin
            add_word(TOK_ZERO);
            zpend = 1'b1;
         end
      end
      if (d[3] != TOK_ZERO) begin
         add_word(d[3]);
      end else if (zpend) begin
         drop_word();
      end
   endfunction

   // Leading (or only) group of one to four digits, most significant first.
   function automatic void read_head(input token_type [0:3] d, input int size);
      if (size <= 1) begin
         add_word(d[0]);
      end else if (size == 2) begin
         if (d[0] != TOK_ZERO) begin
            if (d[0] != TOK_ONE) begin
               add_word(d[0]);
            end
            add_word(TOK_TEN);
         end
         if (d[1] != TOK_ZERO) begin
            add_word(d[1]);
         end
      end else if (size == 3) begin
         add_word(d[0]);
         add_word(TOK_HUNDRED);
         if (d[1] != TOK_ZERO) begin
            add_word(d[1]);
            add_word(TOK_TEN);
         end else begin
            add_word(TOK_ZERO);
         end
         if (d[2] != TOK_ZERO) begin
            add_word(d[2]);
         end else if (d[1] == TOK_ZERO) begin
            drop_word();
         end
      end else begin
         read_four(d);
      end
   endfunction

   function automatic void predict_reading(input req_type r);
      int              cnt;
      int              upper;
      token_type [0:3] d;
      rsp_type         t;
      cnt = int'(r.digit_count);
      if (cnt < 1) begin
         cnt = 1;
      end
      if (cnt > MAX_DIGITS) begin
         cnt = MAX_DIGITS;
      end
      spoken.delete();
      d = '0;
      if (cnt > GROUP_DIGITS) begin
         upper = cnt - GROUP_DIGITS;
         for (int i = 0; i < upper; i++) begin
            d[i] = nibble_digit(r.bcd_digits, cnt - 1 - i);
         end
         read_head(d, upper);
         add_word(TOK_WAN);
         for (int i = 0; i < GROUP_DIGITS; i++) begin
            d[i] = nibble_digit(r.bcd_digits, GROUP_DIGITS - 1 - i);
         end
         read_four(d);
      end else begin
         for (int i = 0; i < cnt; i++) begin
            d[i] = nibble_digit(r.bcd_digits, cnt - 1 - i);
         end
         read_head(d, cnt);
      end
      while (spoken.size() > ENTRY_SLOTS) begin
         drop_word();
      end
      for (int k = 0; k < spoken.size(); k++) begin
         t.token = spoken[k];
         t.last  = (k == spoken.size() - 1);
         expected_tokens = {expected_tokens, t};
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         // Tokens are compared before the request of this edge is predicted; the unit
         // never answers a request on the edge that accepts it.
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: token %0d last %0b with no request waiting",
                           $realtime, rsp_payload.token, rsp_payload.last);
               end
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_payload.token !== want.token || rsp_payload.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: expected token %0d last %0b, got token %0d last %0b",
                              $realtime, want.token, want.last,
                              rsp_payload.token, rsp_payload.last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_reading(req_payload);
         end
      end
      pending_tokens <= expected_tokens.size();
      error_count    <= mismatches;
   end

endmodule

// ===== tb/sv/tb_decimal_to_chinese_numeral_unit.sv =====
// Top of the Chinese numeral unit testbench: clock, reset, request stimulus and the
// token receiver. Depends on dcn_pkg, the unit and dcn_reading_checker.
`timescale 1ns / 1ps

module tb_decimal_to_chinese_numeral_unit;
   import dcn_pkg::*;

   localparam int RANDOM_REQUESTS  = 85;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 40;
   localparam int CYCLE_LIMIT      = 200000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   int   pending_tokens;
   int   error_count;
   int   cycle_count = 0;
   int   burst_left = 0;
   logic long_hold_req = 1'b0;

   always #6 clock = ~clock;

   decimal_to_chinese_numeral_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   dcn_reading_checker reading_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .pending_tokens (pending_tokens),
      .error_count    (error_count)
   );

   function automatic req_type make_req(input logic [BCD_W-1:0] bcd,
                                        input logic [COUNT_W-1:0] cnt);
      req_type r;
      r.bcd_digits  = bcd;
      r.digit_count = cnt;
      return r;
   endfunction

   // A number of random length with zeros favored; nibbles above the count are filler.
   function automatic req_type random_number(input logic leading_zero);
      logic [BCD_W-1:0] bcd;
      int               cnt;
      cnt = $urandom_range(1, MAX_DIGITS);
      for (int i = 0; i < MAX_DIGITS; i++) begin
         bcd[DIGIT_W*i +: DIGIT_W] = ($urandom_range(0, 9) < 4) ? TOK_ZERO :
                                     token_type'($urandom_range(1, 9));
      end
      if (cnt > 1) begin
         bcd[DIGIT_W*(cnt-1) +: DIGIT_W] = leading_zero ? TOK_ZERO :
                                           token_type'($urandom_range(1, 9));
      end
      return make_req(bcd, COUNT_W'(cnt));
   endfunction

   // The sender offers requests in bursts with idle gaps in between.
   task automatic offer_request(input req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      stall_mode_type mode;
      int             span;
      logic           held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(10, 60);
         for (int c = 0; c < span; c++) begin
            if (long_hold_req && !held) begin
               // Hold off long enough for the unit to back up into its input.
               held = 1'b1;
               rsp_stall <= 1'b1;
               repeat (LONG_HOLD_CYCLES) @(posedge clock);
            end
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= c[0];
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_request(make_req(32'h0000_0000, 4'd1));
      offer_request(make_req(32'h0000_0009, 4'd1));
      offer_request(make_req(32'h0000_0010, 4'd2));
      offer_request(make_req(32'h0000_0011, 4'd2));
      offer_request(make_req(32'h0000_0090, 4'd2));
      offer_request(make_req(32'h0000_0000, 4'd2));
      offer_request(make_req(32'h0000_0005, 4'd2));
      offer_request(make_req(32'h0000_0100, 4'd3));
      offer_request(make_req(32'h0000_0101, 4'd3));
      offer_request(make_req(32'h0000_0110, 4'd3));
      offer_request(make_req(32'h0000_0999, 4'd3));
      offer_request(make_req(32'h0000_1000, 4'd4));
      offer_request(make_req(32'h0000_1001, 4'd4));
      offer_request(make_req(32'h0000_1010, 4'd4));
      offer_request(make_req(32'h0000_0110, 4'd4));
      offer_request(make_req(32'h0000_0000, 4'd4));
      offer_request(make_req(32'h0001_0000, 4'd5));
      offer_request(make_req(32'h0010_0000, 4'd6));
      offer_request(make_req(32'h1000_0001, 4'd8));
      offer_request(make_req(32'h9999_9999, 4'd8));
      offer_request(make_req(32'h2003_0400, 4'd8));
      offer_request(make_req(32'hFFFF_FFFF, 4'd8));
      offer_request(make_req(32'h0000_0007, 4'd0));
      offer_request(make_req(32'h1234_5678, 4'd15));
      offer_request(make_req(32'hABCD_EF01, 4'd9));

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 30) begin
            long_hold_req <= 1'b1;
         end
         if (n == 70) begin
            // Let every outstanding token come out before the next request.
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_tokens != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            offer_request(random_number(1'b0));
         end else if (pick < 17) begin
            offer_request(random_number(1'b1));
         end else begin
            offer_request(make_req($urandom, COUNT_W'($urandom_range(0, 15))));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_tokens != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_tokens == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
